// ===== design/block_reverse_reorder_assert.svh =====
// Assertion macros used by the reorder block's front end.
`ifndef BLOCK_REVERSE_REORDER_ASSERT_SVH
`define BLOCK_REVERSE_REORDER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define BRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("block_reverse_reorder assertion failed");
// Consequent checked on the clock after the antecedent.
`define BRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block_reverse_reorder assertion failed");
`else
`define BRR_ASSERT(lbl, prop)
`define BRR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/brr_pkg.sv =====
// Shared constants and types of the group reverse reorder block.
`timescale 1ns / 1ps
package brr_pkg;

  localparam int VALUE_W       = 32;
  localparam int GS_W          = 5;
  localparam logic [GS_W-1:0] GROUP_SIZE_RST = 5'd2;
  localparam int MAX_GROUP_DEF = 16;
  localparam int CMD_DEPTH     = 2;

  // back end hands a buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage

// ===== design/brr_ifs.sv =====
// Stream interfaces for the input and result channels.
`timescale 1ns / 1ps
interface brr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [brr_pkg::VALUE_W-1:0] value;
  logic                              seq_end;

  modport source (output valid, output value, output seq_end, input ready);
  modport sink (input valid, input value, input seq_end, output ready);
endinterface

interface brr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [brr_pkg::VALUE_W-1:0] out_value;
  logic                              run_last;
  logic                              out_seq_end;

  modport source (output valid, output out_value, output run_last, output out_seq_end,
                  input ready);
  modport sink (input valid, input out_value, input run_last, input out_seq_end,
                output ready);
endinterface

// ===== design/brr_front.sv =====
// Front end: config register, buffer writes, group closing and bank tracking.
`timescale 1ns / 1ps
`include "block_reverse_reorder_assert.svh"
module brr_front #(
  parameter int MAX_GROUP = brr_pkg::MAX_GROUP_DEF,
  localparam int AW = $clog2(MAX_GROUP),
  localparam int CW = $clog2(MAX_GROUP + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [brr_pkg::GS_W-1:0]    cfg_wdata,
  brr_in_if.sink                      items,
  output logic                        wr_en,
  output logic [AW:0]                 wr_addr,
  output logic [brr_pkg::VALUE_W-1:0] wr_data,
  output logic                        push,
  output logic [CW+2:0]               push_data,
  input  logic                        push_ready,
  input  brr_pkg::bank_free_t         bank_free
);

  localparam int KW = (CW > brr_pkg::GS_W) ? CW : brr_pkg::GS_W;

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          seq_end;
  } cmd_t;

  logic [brr_pkg::GS_W-1:0] group_size;
  logic [CW-1:0]            fill;
  logic                     wbank;
  logic [1:0]               busy;
  logic [1:0]               busy_next;

  logic          acc;
  logic [CW-1:0] n;
  logic [KW-1:0] k;
  logic [KW-1:0] gs_w;
  logic          full;
  logic          close;
  cmd_t          cmd;

  assign items.ready = !busy[wbank];
  assign acc         = items.valid && items.ready;
  assign n           = CW'(fill + 1'b1);

  always_comb begin
    gs_w = KW'(group_size);
    if (gs_w > KW'(MAX_GROUP)) begin
      k = KW'(MAX_GROUP);
    end else if (gs_w == '0) begin
      k = KW'(1);
    end else begin
      k = gs_w;
    end
  end

  assign full  = KW'(n) >= k;
  assign close = acc && (full || items.seq_end);

  assign wr_en   = acc;
  assign wr_addr = {wbank, fill[AW-1:0]};
  assign wr_data = items.value;

  always_comb begin
    cmd.bank    = wbank;
    cmd.count   = n;
    cmd.rev     = full;
    cmd.seq_end = items.seq_end;
  end

  assign push      = close;
  assign push_data = cmd;

  always_comb begin
    busy_next = busy;
    if (bank_free.valid) begin
      busy_next[bank_free.bank] = 1'b0;
    end
    if (close) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= brr_pkg::GROUP_SIZE_RST;
      fill       <= '0;
      wbank      <= 1'b0;
      busy       <= '0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      busy <= busy_next;
      if (close) begin
        fill  <= '0;
        wbank <= ~wbank;
      end else if (acc) begin
        fill <= n;
      end
    end
  end

  // two banks bound the commands in flight to the queue depth
  `BRR_ASSERT(a_push_has_room, !push || push_ready)
  `BRR_ASSERT(a_free_only_busy, !bank_free.valid || busy[bank_free.bank])
  `BRR_ASSERT_NEXT(a_close_flips_bank, push, wbank != $past(wbank))

endmodule

// ===== design/brr_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module brr_cmd_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = brr_pkg::CMD_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_ready = count != NW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : PW'(wptr + 1'b1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : PW'(rptr + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= NW'(count + 1'b1);
        2'b01:   count <= NW'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/brr_back.sv =====
// Back end: ping-pong group buffer, read sequencer and output register.
`timescale 1ns / 1ps
module brr_back #(
  parameter int MAX_GROUP = brr_pkg::MAX_GROUP_DEF,
  localparam int AW = $clog2(MAX_GROUP),
  localparam int CW = $clog2(MAX_GROUP + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [AW:0]                 wr_addr,
  input  logic [brr_pkg::VALUE_W-1:0] wr_data,
  input  logic                        cmd_valid,
  input  logic [CW+2:0]               cmd_data,
  output logic                        cmd_pop,
  output brr_pkg::bank_free_t         bank_free,
  brr_out_if.source                   results
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          rev;
    logic          seq_end;
  } cmd_t;

  logic [brr_pkg::VALUE_W-1:0] mem [2**(AW+1)];

  cmd_t          cmd_in;
  cmd_t          cur;
  logic          running;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          is_last;
  logic          issue;
  logic          load;

  logic                        rd_valid;
  logic [brr_pkg::VALUE_W-1:0] rd_data;
  logic                        rd_last;
  logic                        rd_end;

  logic                        out_valid;
  logic [brr_pkg::VALUE_W-1:0] out_data;
  logic                        out_last;
  logic                        out_end;

  assign cmd_in  = cmd_data;
  assign load    = !out_valid || results.ready;
  assign issue   = running && (!rd_valid || load);
  assign is_last = CW'(idx + 1'b1) == cur.count;
  assign pos     = cur.rev ? CW'(cur.count - 1'b1 - idx) : idx;
  assign cmd_pop = cmd_valid && (!running || (issue && is_last));

  // bank is free once its last entry has been read out
  assign bank_free.valid = issue && is_last;
  assign bank_free.bank  = cur.bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[{cur.bank, pos[AW-1:0]}];
      rd_last <= is_last;
      rd_end  <= is_last && cur.seq_end;
    end
    if (load && rd_valid) begin
      out_data <= rd_data;
      out_last <= rd_last;
      out_end  <= rd_end;
    end
    if (cmd_pop) begin
      cur <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        running <= 1'b1;
        idx     <= '0;
      end else if (issue && is_last) begin
        running <= 1'b0;
      end else if (issue) begin
        idx <= CW'(idx + 1'b1);
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (load) begin
        rd_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= rd_valid;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.out_value   = out_data;
  assign results.run_last    = out_last;
  assign results.out_seq_end = out_end;

endmodule

// ===== design/block_reverse_reorder.sv =====
// Top level of the group reverse reorder block.
//
//   channel    dir  beat                                   handshake
//   items      in   value, seq_end                         valid/ready
//   results    out  out_value, run_last, out_seq_end       valid/ready
//   cfg        in   cfg_wdata (group_size)                 cfg_we, no wait
//
// A bank is held from its first write until its last read. The front end can fill one
// bank while the back end reads out the other. items.ready drops only while both banks
// are held. With the back end idle, a closed group's first result goes from its closing
// beat through the command queue, the back end's command register, the buffer read and
// the output register. Reset is synchronous and clears control only; buffer contents are
// not cleared. A stall on results backs up through the read pipeline and, once both
// banks are held, into items.
`timescale 1ns / 1ps
module block_reverse_reorder #(
  parameter int MAX_GROUP = brr_pkg::MAX_GROUP_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [brr_pkg::GS_W-1:0] cfg_wdata,
  brr_in_if.sink                   items,
  brr_out_if.source                results
);

  localparam int AW    = $clog2(MAX_GROUP);
  localparam int CW    = $clog2(MAX_GROUP + 1);
  localparam int CMD_W = CW + 3;

  logic                        wr_en;
  logic [AW:0]                 wr_addr;
  logic [brr_pkg::VALUE_W-1:0] wr_data;
  logic                        push;
  logic [CMD_W-1:0]            push_data;
  logic                        push_ready;
  logic                        pop;
  logic                        pop_valid;
  logic [CMD_W-1:0]            pop_data;
  brr_pkg::bank_free_t         bank_free;

  brr_front #(
    .MAX_GROUP (MAX_GROUP)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .items      (items),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .bank_free  (bank_free)
  );

  brr_cmd_fifo #(
    .W (CMD_W)
  ) u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  brr_back #(
    .MAX_GROUP (MAX_GROUP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .cmd_valid (pop_valid),
    .cmd_data  (pop_data),
    .cmd_pop   (pop),
    .bank_free (bank_free),
    .results   (results)
  );

endmodule
